### src/ntd_pkg.sv
// shared types, constants and symbol table for the nibble text decompressor
`default_nettype none
package ntd_pkg;

  // stream field sizes
  localparam logic [3:0] WIDTH_BASE  = 4'd5;
  localparam logic [4:0] SHORT_BITS  = 5'd4;
  localparam logic [3:0] RAW_WIDTH   = 4'd8;
  localparam logic [4:0] BYTE_BITS   = 5'd8;
  localparam logic [4:0] WIDTH_FIELD = 5'd2;

  // header progress of the text being decoded
  typedef enum logic [1:0] {
    STAGE_LEN_LO = 2'd0,
    STAGE_LEN_HI = 2'd1,
    STAGE_BODY   = 2'd2,
    STAGE_DONE   = 2'd3
  } stage_t;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_t;

  // output beat
  typedef struct packed {
    logic [7:0] char_out;
    logic       text_done;
    logic       last;
  } out_t;

  // decoded symbols of one byte, passed from front to back
  typedef struct packed {
    logic [7:0] sym0;
    logic       done0;
    logic [7:0] sym1;
    logic       done1;
    logic       two;
    logic       use_rom;
  } rec_t;

  // fixed symbol decode table
  localparam logic [7:0] SYMBOL_ROM [128] = '{
    8'h00,8'h20,8'h61,8'h65,8'h74,8'h6F,8'h6E,8'h69,
    8'h73,8'h72,8'h64,8'h6C,8'h68,8'h75,8'h67,8'h66,
    8'h63,8'h77,8'h79,8'h70,8'h62,8'h6D,8'h6B,8'h2C,
    8'h76,8'h53,8'h41,8'h2E,8'h54,8'h27,8'h50,8'h4D,
    8'h78,8'h42,8'h43,8'h49,8'h52,8'h47,8'h44,8'h57,
    8'h48,8'h71,8'h45,8'h2D,8'h7A,8'h4E,8'h46,8'h4B,
    8'h4C,8'h30,8'h6A,8'h3A,8'h35,8'h31,8'h59,8'h4A,
    8'h38,8'h5C,8'h55,8'h3F,8'h37,8'h33,8'h51,8'h3B,
    8'h32,8'h21,8'h34,8'h36,8'h39,8'h0D,8'h0A,8'h09,
    8'h4F,8'h56,8'h58,8'h5A,8'h28,8'h29,8'h2A,8'h2B,
    8'h22,8'h23,8'h24,8'h25,8'h26,8'h3C,8'h3D,8'h3E,
    8'h2F,8'h40,8'h5B,8'h5D,8'h5E,8'h5F,8'h60,8'h07,
    8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h08,8'h0B,
    8'h0C,8'h0E,8'h0F,8'h10,8'h11,8'h12,8'h13,8'h14,
    8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,8'h1B,8'h1C,
    8'h1D,8'h1E,8'h1F,8'h7B,8'h7C,8'h7D,8'h7E,8'h7F
  };

endpackage
`default_nettype wire

### src/ntd_front.sv
// front end: header parsing, bit buffer and decode of up to two codes per byte
`default_nettype none
module ntd_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         msb_first,
  input  wire logic         in_valid,
  input  wire logic         in_stall,
  input  wire ntd_pkg::in_t in_data,
  output logic              push,
  output ntd_pkg::rec_t     push_rec
);

  typedef struct packed {
    logic        ok;
    logic [23:0] bits;
    logic [4:0]  held;
    logic [7:0]  sym;
  } step_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // one code from the head of the buffer
  function automatic step_t decode_step(input logic [23:0] bb, input logic [4:0] hh,
                                        input logic [3:0] lw, input logic msb);
    step_t      r;
    logic [3:0] code;
    logic [7:0] raw;
    logic [7:0] rr;
    logic [4:0] need;
    r.ok   = 1'b0;
    r.bits = bb;
    r.held = hh;
    r.sym  = 8'd0;
    code   = msb ? {bb[0], bb[1], bb[2], bb[3]} : bb[3:0];
    need   = ntd_pkg::SHORT_BITS + {1'b0, lw};
    raw    = bb[11:4] & (8'hFF >> (ntd_pkg::RAW_WIDTH - lw));
    rr     = rev8(raw) >> (ntd_pkg::RAW_WIDTH - lw);
    if (hh >= ntd_pkg::SHORT_BITS) begin
      if (code != 4'd0) begin
        r.ok   = 1'b1;
        r.bits = bb >> ntd_pkg::SHORT_BITS;
        r.held = hh - ntd_pkg::SHORT_BITS;
        r.sym  = {4'd0, code};
      end else if (hh >= need) begin
        r.ok   = 1'b1;
        r.bits = bb >> need;
        r.held = hh - need;
        r.sym  = msb ? rr : raw;
      end
    end
    return r;
  endfunction

  ntd_pkg::stage_t stage, stage_next;
  logic [15:0] text_length, text_length_next;
  logic [15:0] emitted_count, emitted_count_next;
  logic [23:0] bit_buffer, bit_buffer_next;
  logic [4:0]  bits_held, bits_held_next;
  logic [3:0]  long_width, long_width_next;
  logic        width_known, width_known_next;

  logic            accept;
  ntd_pkg::stage_t eff_stage;
  logic [15:0]     eff_len, eff_cnt;
  logic [23:0]     eff_bits;
  logic [4:0]      eff_held;
  logic [3:0]      eff_lw;
  logic            eff_wk;
  logic [7:0]      ins;
  logic [23:0]     b1, b2, fin_bits;
  logic [4:0]      h2, fin_held;
  logic [1:0]      wfield;
  logic [3:0]      lw_n;
  step_t           s0, s1;
  logic            go0, go1;
  logic [15:0]     cnt1, cnt2;
  logic            text_end;
  logic [15:0]     len_hi;

  assign accept = in_valid && !in_stall;

  // state as seen by this byte, after an optional restart
  always_comb begin
    eff_stage = in_data.first ? ntd_pkg::STAGE_LEN_LO : stage;
    eff_len   = in_data.first ? 16'd0 : text_length;
    eff_cnt   = in_data.first ? 16'd0 : emitted_count;
    eff_bits  = in_data.first ? 24'd0 : bit_buffer;
    eff_held  = in_data.first ? 5'd0 : bits_held;
    eff_lw    = in_data.first ? ntd_pkg::WIDTH_BASE : long_width;
    eff_wk    = in_data.first ? 1'b0 : width_known;
    len_hi    = {in_data.data_byte, eff_len[7:0]};
  end

  // body datapath: append byte, width field, two decode steps
  always_comb begin
    ins    = msb_first ? rev8(in_data.data_byte) : in_data.data_byte;
    b1     = eff_bits | ({16'd0, ins} << eff_held);
    wfield = msb_first ? {b1[0], b1[1]} : b1[1:0];
    if (!eff_wk) begin
      lw_n = {2'd0, wfield} + ntd_pkg::WIDTH_BASE;
      b2   = b1 >> ntd_pkg::WIDTH_FIELD;
      h2   = eff_held + ntd_pkg::BYTE_BITS - ntd_pkg::WIDTH_FIELD;
    end else begin
      lw_n = eff_lw;
      b2   = b1;
      h2   = eff_held + ntd_pkg::BYTE_BITS;
    end
    s0   = decode_step(b2, h2, lw_n, msb_first);
    go0  = s0.ok && (eff_cnt < eff_len);
    cnt1 = eff_cnt + 16'(go0);
    s1   = decode_step(s0.bits, s0.held, lw_n, msb_first);
    go1  = go0 && s1.ok && (cnt1 < eff_len);
    cnt2 = cnt1 + 16'(go1);
    text_end = (cnt2 >= eff_len);
    if (go1) begin
      fin_bits = s1.bits;
      fin_held = s1.held;
    end else if (go0) begin
      fin_bits = s0.bits;
      fin_held = s0.held;
    end else begin
      fin_bits = b2;
      fin_held = h2;
    end
  end

  // header stage sequencing
  always_comb begin
    stage_next = stage;
    if (accept) begin
      unique case (eff_stage)
        ntd_pkg::STAGE_LEN_LO: stage_next = ntd_pkg::STAGE_LEN_HI;
        ntd_pkg::STAGE_LEN_HI: begin
          stage_next = (len_hi == 16'd0) ? ntd_pkg::STAGE_DONE : ntd_pkg::STAGE_BODY;
        end
        ntd_pkg::STAGE_BODY: begin
          stage_next = text_end ? ntd_pkg::STAGE_DONE : ntd_pkg::STAGE_BODY;
        end
        ntd_pkg::STAGE_DONE: stage_next = ntd_pkg::STAGE_DONE;
        default: stage_next = ntd_pkg::STAGE_DONE;
      endcase
    end
  end

  // stream state updates
  always_comb begin
    text_length_next   = text_length;
    emitted_count_next = emitted_count;
    bit_buffer_next    = bit_buffer;
    bits_held_next     = bits_held;
    long_width_next    = long_width;
    width_known_next   = width_known;
    if (accept) begin
      text_length_next   = eff_len;
      emitted_count_next = eff_cnt;
      bit_buffer_next    = eff_bits;
      bits_held_next     = eff_held;
      long_width_next    = eff_lw;
      width_known_next   = eff_wk;
      unique case (eff_stage)
        ntd_pkg::STAGE_LEN_LO: text_length_next = {8'd0, in_data.data_byte};
        ntd_pkg::STAGE_LEN_HI: text_length_next = len_hi;
        ntd_pkg::STAGE_BODY: begin
          emitted_count_next = cnt2;
          long_width_next    = lw_n;
          width_known_next   = 1'b1;
          bit_buffer_next    = text_end ? 24'd0 : fin_bits;
          bits_held_next     = text_end ? 5'd0 : fin_held;
        end
        default: ;
      endcase
    end
  end

  // decoded symbols toward the queue
  always_comb begin
    push             = accept && (eff_stage == ntd_pkg::STAGE_BODY) && go0;
    push_rec.sym0    = s0.sym;
    push_rec.done0   = (cnt1 == eff_len);
    push_rec.sym1    = s1.sym;
    push_rec.done1   = (cnt2 == eff_len);
    push_rec.two     = go1;
    push_rec.use_rom = (lw_n < ntd_pkg::RAW_WIDTH);
  end

  // stream state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ntd_pkg::STAGE_LEN_LO;
      text_length   <= 16'd0;
      emitted_count <= 16'd0;
      bit_buffer    <= 24'd0;
      bits_held     <= 5'd0;
      long_width    <= ntd_pkg::WIDTH_BASE;
      width_known   <= 1'b0;
    end else begin
      stage         <= stage_next;
      text_length   <= text_length_next;
      emitted_count <= emitted_count_next;
      bit_buffer    <= bit_buffer_next;
      bits_held     <= bits_held_next;
      long_width    <= long_width_next;
      width_known   <= width_known_next;
    end
  end

endmodule
`default_nettype wire

### src/ntd_queue.sv
// short queue of decoded symbol groups between front and back
`default_nettype none
module ntd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ntd_pkg::rec_t push_rec,
  input  wire logic          pop,
  output ntd_pkg::rec_t      head,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ntd_pkg::rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/ntd_back.sv
// back end: symbol table lookup and one character beat per cycle while the output is not stalled
`default_nettype none
module ntd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rec_valid,
  input  wire ntd_pkg::rec_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ntd_pkg::out_t      out_data
);

  logic          sel, sel_next;
  logic          load;
  logic [7:0]    sym;
  ntd_pkg::out_t beat;

  // pick the next character of the head group
  always_comb begin
    load          = rec_valid && (!out_valid || !out_stall);
    sym           = sel ? head.sym1 : head.sym0;
    beat.char_out = head.use_rom ? ntd_pkg::SYMBOL_ROM[sym[6:0]] : sym;
    beat.text_done = sel ? head.done1 : head.done0;
    beat.last     = sel || !head.two;
    pop           = load && beat.last;
    sel_next      = load ? (head.two && !sel) : sel;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= beat;
    end
  end

  // output valid and group position
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      sel <= sel_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/nibble_text_decompressor_top.sv
// top level of the nibble text decompressor
//
//  channel  | signals                      | beat
//  ---------+------------------------------+--------------------------------------
//  in       | in_valid, in_stall, in_data  | one compressed byte, first flag
//  out      | out_valid, out_stall, out_data | one character, text_done, last
//  config   | cfg_write, cfg_data          | msb_first bit order
//
// a byte is taken every cycle while the symbol queue has room; it is decoded in
// the cycle it is taken and queued at that edge; its first character then passes
// from the queue head through the output register.
// the output port moves one character per cycle while out_stall is low, so a byte
// giving two characters takes two output beats; that port sets the sustained rate.
// rst is synchronous and clears all stream state and the queue; no clearing pass.
// in_stall is high only while the queue is full.
`default_nettype none
module nibble_text_decompressor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic          cfg_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ntd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ntd_pkg::out_t      out_data
);

  logic          msb_first;
  logic          push, pop, q_empty, q_full;
  ntd_pkg::rec_t push_rec, head;

  // bit order register
  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first <= 1'b0;
    end else if (cfg_write) begin
      msb_first <= cfg_data;
    end
  end

  assign in_stall = q_full;

  ntd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msb_first (msb_first),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_rec  (push_rec)
  );

  ntd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ntd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### tb/nibble_text_decompressor_top_test.sv
// self-checking testbench for the nibble text decompressor top level
`timescale 1ns / 1ps
module nibble_text_decompressor_top_test;

  // one code of the body: short symbol, or escape plus long symbol
  typedef struct packed {
    logic       esc;
    logic [7:0] val;
  } sym_code_t;

  localparam int PHASE_BEATS = 140;
  localparam int HOLD_CYCLES = 60;

  // decoder state mirror and queue of characters still to come
  class text_scoreboard;
    bit               msb_first;
    ntd_pkg::stage_t  stage;
    logic [15:0]      text_len;
    logic [15:0]      emitted;
    int unsigned      bitq;
    int               held;
    int               long_w;
    bit               width_known;
    ntd_pkg::out_t    char_q[$];
    int               errors;
    int               checked;
    int               beats;

    function new();
      msb_first = 1'b0;
      errors = 0;
      checked = 0;
      beats = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      stage = ntd_pkg::STAGE_LEN_LO;
      text_len = '0;
      emitted = '0;
      bitq = 0;
      held = 0;
      long_w = ntd_pkg::WIDTH_BASE;
      width_known = 1'b0;
    endfunction

    function int unsigned flip(int unsigned v, int n);
      int unsigned r;
      r = 0;
      for (int i = 0; i < n; i++) r[n-1-i] = v[i];
      return r;
    endfunction

    // next n bits of the buffer as a field value
    function int unsigned field_value(int n);
      int unsigned raw;
      raw = bitq & ((32'd1 << n) - 1);
      return msb_first ? flip(raw, n) : raw;
    endfunction

    function void drop(int n);
      bitq = (bitq >> n) & 32'hFF_FFFF;
      held -= n;
    endfunction

    function int pending();
      return char_q.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // accepted input beat: work out the characters it produces
    function void note_beat(ntd_pkg::in_t b);
      int unsigned   data;
      int unsigned   code;
      int unsigned   sym;
      int            made;
      bit            stop;
      ntd_pkg::out_t made_r [2];
      beats++;
      if (b.first) clear_stream();
      case (stage)
        ntd_pkg::STAGE_LEN_LO: begin
          text_len = {8'h00, b.data_byte};
          stage = ntd_pkg::STAGE_LEN_HI;
          return;
        end
        ntd_pkg::STAGE_LEN_HI: begin
          text_len[15:8] = b.data_byte;
          stage = (text_len == 16'd0) ? ntd_pkg::STAGE_DONE : ntd_pkg::STAGE_BODY;
          return;
        end
        ntd_pkg::STAGE_DONE: return;
        default: ;
      endcase
      data = msb_first ? flip(b.data_byte, 8) : b.data_byte;
      bitq = (bitq | (data << held)) & 32'hFF_FFFF;
      held += 8;
      // width field sits at the head of the body
      if (!width_known) begin
        long_w = field_value(ntd_pkg::WIDTH_FIELD) + ntd_pkg::WIDTH_BASE;
        drop(ntd_pkg::WIDTH_FIELD);
        width_known = 1'b1;
      end
      made = 0;
      stop = 1'b0;
      while (!stop && made < 2 && emitted < text_len && held >= ntd_pkg::SHORT_BITS) begin
        code = field_value(ntd_pkg::SHORT_BITS);
        sym = code;
        if (code != 0) begin
          drop(ntd_pkg::SHORT_BITS);
        end else if (held < ntd_pkg::SHORT_BITS + long_w) begin
          stop = 1'b1;
        end else begin
          drop(ntd_pkg::SHORT_BITS);
          sym = field_value(long_w);
          drop(long_w);
        end
        if (!stop) begin
          if (long_w < ntd_pkg::RAW_WIDTH) sym = ntd_pkg::SYMBOL_ROM[sym[6:0]];
          emitted++;
          made_r[made].char_out = sym[7:0];
          made_r[made].text_done = (emitted == text_len);
          made_r[made].last = 1'b0;
          made++;
        end
      end
      // text complete: leftover bits are dropped
      if (emitted >= text_len) begin
        stage = ntd_pkg::STAGE_DONE;
        bitq = 0;
        held = 0;
      end
      for (int i = 0; i < made; i++) begin
        if (i == made - 1) made_r[i].last = 1'b1;
        char_q.push_back(made_r[i]);
      end
    endfunction

    // accepted output beat against the oldest expected character
    function void check_char(ntd_pkg::out_t got);
      ntd_pkg::out_t want;
      if (char_q.size() == 0) begin
        report($sformatf("unexpected character %02h done %0b last %0b",
                         got.char_out, got.text_done, got.last));
        return;
      end
      want = char_q.pop_front();
      checked++;
      if (got.char_out !== want.char_out || got.text_done !== want.text_done ||
          got.last !== want.last)
        report($sformatf("mismatch: want char %02h done %0b last %0b, got char %02h done %0b last %0b",
                         want.char_out, want.text_done, want.last,
                         got.char_out, got.text_done, got.last));
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_write = 1'b0;
  logic          cfg_data = 1'b0;
  logic          in_valid = 1'b0;
  ntd_pkg::in_t  in_data = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  ntd_pkg::out_t out_data;

  text_scoreboard sb = new();
  ntd_pkg::in_t   stim_q[$];
  bit             stream_bits[$];
  sym_code_t      text_codes[$];
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             hold_req = 0;
  int             hold_left = 0;
  int             texts = 0;

  nibble_text_decompressor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // watchdog
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if (out_valid && !out_stall) sb.check_char(out_data);
    end
  end

  function automatic void add_code(bit esc, int unsigned val);
    sym_code_t c;
    c.esc = esc;
    c.val = val[7:0];
    text_codes.push_back(c);
  endfunction

  function automatic void put_field(int unsigned v, int n, bit msb);
    for (int i = 0; i < n; i++) stream_bits.push_back(v[msb ? n - 1 - i : i]);
  endfunction

  // header, bit-packed body of text_codes, padding; cut drops final body bytes
  function automatic void pack_text(int len, int wsel, int pad, int cut, bit msb, bit lead_first);
    ntd_pkg::in_t b;
    int           nbytes;
    b.first = lead_first;
    b.data_byte = len[7:0];
    stim_q.push_back(b);
    b.first = 1'b0;
    b.data_byte = len[15:8];
    stim_q.push_back(b);
    if (len[15:0] != 0) begin
      stream_bits.delete();
      put_field(wsel, 2, msb);
      foreach (text_codes[k]) begin
        if (text_codes[k].esc) begin
          put_field(0, 4, msb);
          put_field(text_codes[k].val, 5 + wsel, msb);
        end else begin
          put_field(text_codes[k].val, 4, msb);
        end
      end
      while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(1)));
      nbytes = stream_bits.size() / 8 - cut;
      for (int i = 0; i < nbytes; i++) begin
        for (int j = 0; j < 8; j++) b.data_byte[msb ? 7 - j : j] = stream_bits[8 * i + j];
        stim_q.push_back(b);
      end
    end
    repeat (pad) begin
      b.data_byte = 8'($urandom_range(255));
      stim_q.push_back(b);
    end
    text_codes.delete();
    texts++;
  endfunction

  // mostly well-formed texts, some with odd lengths, cut short or followed by noise
  function automatic void random_text(bit msb);
    int           wsel;
    int           n;
    int           len;
    int           kind;
    int           cut;
    bit           esc;
    ntd_pkg::in_t b;
    wsel = $urandom_range(3);
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      esc = ($urandom_range(99) < 35);
      add_code(esc, esc ? $urandom_range((1 << (5 + wsel)) - 1) : $urandom_range(1, 15));
    end
    kind = $urandom_range(99);
    len = n;
    cut = 0;
    if (kind < 8) len = 0;
    else if (kind < 16) len = n + $urandom_range(1, 3);
    else if (kind < 24) len = $urandom_range(1, n);
    else if (kind < 27) len = $urandom_range(16'hFFFF);
    else if (kind < 32) cut = 1;
    pack_text(len, wsel, $urandom_range(2), cut, msb, 1'b1);
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 3)) begin
        b.data_byte = 8'($urandom_range(255));
        b.first = 1'($urandom_range(1));
        stim_q.push_back(b);
      end
    end
  endfunction

  // offer one beat after a random gap, return once it is taken
  task automatic send_beat(input ntd_pkg::in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic play(input int n);
    repeat (n) send_beat(stim_q.pop_front());
  endtask

  // sender pauses until every expected character is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input bit msb, input int idle_pct, input int stall_pct,
                           input bit squeeze);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= msb;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.msb_first = msb;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (stim_q.size() < PHASE_BEATS) random_text(msb);
    play(stim_q.size() / 2);
    // drain, then hold the output while the input keeps coming
    if (squeeze) begin
      wait_drained();
      hold_req = HOLD_CYCLES;
    end
    play(stim_q.size());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: first byte without first flag, widest short-width escape
    add_code(1'b0, 1);
    add_code(1'b1, 8'h1F);
    pack_text(2, 0, 1, 0, 1'b0, 1'b0);
    // zero length text with padding
    pack_text(0, 0, 1, 0, 1'b0, 1'b1);
    // raw width: extreme escapes, no table lookup
    add_code(1'b1, 8'hFF);
    add_code(1'b1, 8'h00);
    add_code(1'b0, 15);
    pack_text(3, 3, 0, 0, 1'b0, 1'b1);
    // six-bit escape
    add_code(1'b1, 8'h3F);
    add_code(1'b0, 15);
    pack_text(2, 1, 0, 0, 1'b0, 1'b1);
    // maximum length, dropped by a restart
    add_code(1'b1, 8'h7F);
    add_code(1'b0, 2);
    add_code(1'b0, 3);
    pack_text(16'hFFFF, 2, 0, 0, 1'b0, 1'b1);
    // single character then trailing padding
    add_code(1'b0, 15);
    pack_text(1, 0, 2, 0, 1'b0, 1'b1);
    play(stim_q.size());

    // random phases over bit orders and handshake pressure
    run_phase(1'b1, 0, 0, 1'b0);
    run_phase(1'b0, 68, 0, 1'b0);
    run_phase(1'b1, 0, 68, 1'b1);
    run_phase(1'b0, 13, 13, 1'b0);
    run_phase(1'b1, 13, 13, 1'b1);
    run_phase(1'b0, 0, 0, 1'b0);

    wait_drained();
    repeat (6) @(posedge clk);
    $display("ran %0d input bytes over %0d texts and checked %0d characters,",
             sb.beats, texts, sb.checked);
    $display("both bit orders, long widths 5 to 8, restarts, padding and output hold-offs");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d characters missing", sb.errors, sb.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
